[design/pkc_pkg.sv]
package pkc_pkg;

    localparam int PERIOD_W     = 11;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int CMD_W        = 2;
    localparam int IN_W         = 32;
    localparam int KIDX_W       = 10;
    localparam int RHS_W        = 48;
    localparam int DIAG_W       = 32;
    localparam int FRAC_W       = 16;
    localparam int PERIOD_RESET = 1024;
    localparam int TERM_RESET   = 1024;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PRESSURE_OFFSET = 2'd0,
        REG_PERIOD_STEPS    = 2'd1,
        REG_TRUNCATED_MODE  = 2'd2,
        REG_TERM_COUNT      = 2'd3
    } cfg_reg_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_EVAL   = 2'd0,
        CMD_FLOW   = 2'd1,
        CMD_KERNEL = 2'd2,
        CMD_SPARE  = 2'd3
    } cmd_t;

    // controls from the sequencer to the multiply-accumulate datapath
    typedef struct packed {
        logic clear;
        logic mul_en;
        logic acc_prod;
        logic acc_offset;
        logic round;
    } pkc_mac_ctrl_t;

endpackage

[design/pkc_mac.sv]
module pkc_mac #(
    parameter int STORE_W = 32,
    parameter int ACC_W   = 77
)
(
    input  logic                                   clk,
    input  pkc_pkg::pkc_mac_ctrl_t                 ctrl,
    input  logic signed [STORE_W-1:0]              kernel_word,
    input  logic signed [STORE_W-1:0]              flow_word,
    input  logic signed [pkc_pkg::CFG_DATA_W-1:0]  offset,
    output logic signed [pkc_pkg::RHS_W-1:0]       rhs,
    output logic                                   sat
);
    import pkc_pkg::*;

    localparam int PROD_W = 2 * STORE_W;
    localparam int TOP_W  = RHS_W + FRAC_W;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_W - 1);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  offset_ext;
    logic [ACC_W-1:TOP_W-1]   upper;
    logic                     in_range;

    assign offset_ext = ACC_W'(offset) <<< FRAC_W;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (ctrl.acc_prod)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
        else if (ctrl.acc_offset)
        begin
            acc_next = acc_reg + offset_ext;
        end
        else if (ctrl.round)
        begin
            // negate and round half up in one add
            acc_next = HALF - acc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= kernel_word * flow_word;
        end
        acc_reg <= acc_next;
    end

    assign upper    = acc_reg[ACC_W-1:TOP_W-1];
    assign in_range = (&upper) || (~|upper);
    assign sat      = !in_range;

    always_comb
    begin
        if (in_range)
        begin
            rhs = acc_reg[TOP_W-1:FRAC_W];
        end
        else if (acc_reg[ACC_W-1])
        begin
            rhs = {1'b1, {(RHS_W-1){1'b0}}};
        end
        else
        begin
            rhs = {1'b0, {(RHS_W-1){1'b1}}};
        end
    end

endmodule

[design/periodic_kernel_convolution_bc.sv]
// Periodic FIR boundary term. Items are taken one at a time: in_stall is low
// only while the sequencer is idle, and the next item may be taken while the
// previous result still waits in the output register. An item with a full
// history passes through the memory reads for lags 1 to T-1 (T = terms in
// use), then pipeline drain, offset add, rounding and output load, and returns
// to idle to take the next item. Without a full history, or with T = 1, the
// reads and the drain are skipped. A result held by out_stall keeps the
// sequencer in its output state until the output register frees. Each memory
// has a single read port: flow ring and kernel table are each read once per
// cycle, feeding one multiply-accumulate per cycle. Neither memory is cleared
// after reset; a kernel word must be loaded before use.
module periodic_kernel_convolution_bc #(
    parameter int MAX_PERIOD   = 1024,
    parameter int SAMPLE_WIDTH = 32
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic [pkc_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [pkc_pkg::CFG_DATA_W-1:0]          cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [pkc_pkg::CMD_W-1:0]               cmd,
    input  logic signed [pkc_pkg::IN_W-1:0]         flow_sample,
    input  logic [pkc_pkg::KIDX_W-1:0]              kernel_index,
    input  logic signed [pkc_pkg::IN_W-1:0]         kernel_value,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [pkc_pkg::RHS_W-1:0]        rhs_term,
    output logic signed [pkc_pkg::DIAG_W-1:0]       diag_coeff,
    output logic                                    history_full,
    output logic                                    saturated
);
    import pkc_pkg::*;

    localparam int IDX_W   = $clog2(MAX_PERIOD);
    localparam int STORE_W = (SAMPLE_WIDTH < IN_W) ? SAMPLE_WIDTH : IN_W;
    localparam int SUM_W   = 2 * STORE_W + IDX_W;
    localparam int ACC_W   = ((SUM_W > RHS_W + FRAC_W) ? SUM_W : RHS_W + FRAC_W) + 3;
    localparam int HW      = ((IDX_W > PERIOD_W) ? IDX_W : PERIOD_W) + 1;
    localparam int WIDE_W  = IN_W + 1;
    localparam logic signed [WIDE_W-1:0] SMAX = (WIDE_W'(1) <<< (STORE_W - 1)) - 1;
    localparam logic signed [WIDE_W-1:0] SMIN = -SMAX - 1;
    localparam logic signed [DIAG_W:0] DMAX = ((DIAG_W + 1)'(1) <<< (DIAG_W - 1)) - 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_OFFSET,
        S_ROUND,
        S_OUT
    } state_t;

    function automatic logic [PERIOD_W-1:0] eff_period(input logic [PERIOD_W-1:0] v);
        logic [PERIOD_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = PERIOD_W'(1);
        end
        else if (int'(v) > MAX_PERIOD)
        begin
            r = PERIOD_W'(MAX_PERIOD);
        end
        return r;
    endfunction

    function automatic logic signed [STORE_W-1:0] sat_store(input logic signed [IN_W-1:0] v);
        logic signed [WIDE_W-1:0] wide;
        logic signed [WIDE_W-1:0] r;
        wide = WIDE_W'(v);
        r = wide;
        if (wide > SMAX)
        begin
            r = SMAX;
        end
        else if (wide < SMIN)
        begin
            r = SMIN;
        end
        return STORE_W'(r);
    endfunction

    state_t                          state_reg;
    logic signed [CFG_DATA_W-1:0]    pressure_offset_reg;
    logic [PERIOD_W-1:0]             period_steps_reg;
    logic                            truncated_mode_reg;
    logic [PERIOD_W-1:0]             term_count_reg;
    logic [IDX_W-1:0]                head_reg;
    logic [PERIOD_W-1:0]             count_reg;
    logic [IDX_W-1:0]                ptr_reg;
    logic [PERIOD_W-1:0]             m_reg;
    logic [PERIOD_W-1:0]             last_reg;
    logic                            full_reg;
    logic                            drain_reg;
    logic                            rd_vld_reg;
    logic                            prod_vld_reg;
    logic                            out_valid_reg;

    logic signed [STORE_W-1:0]       flow_mem [MAX_PERIOD];
    logic signed [STORE_W-1:0]       kern_mem [MAX_PERIOD];
    logic signed [STORE_W-1:0]       flow_rd_reg;
    logic signed [STORE_W-1:0]       kern_rd_reg;
    logic signed [STORE_W-1:0]       kernel0_reg;

    logic signed [RHS_W-1:0]         rhs_reg;
    logic signed [DIAG_W-1:0]        diag_reg;
    logic                            full_out_reg;
    logic                            sat_reg;

    logic [PERIOD_W-1:0]             p;
    logic [PERIOD_W-1:0]             terms;
    logic [HW-1:0]                   head_inc;
    logic [IDX_W-1:0]                head_next;
    logic [IDX_W-1:0]                head_cur;
    logic [PERIOD_W-1:0]             count_next;
    logic                            full_now;
    logic                            accept;
    logic                            is_flow;
    logic                            kern_we;
    logic [IDX_W-1:0]                kaddr;
    logic                            out_load;
    logic signed [DIAG_W:0]          diag_neg;
    logic signed [DIAG_W-1:0]        diag_now;
    pkc_mac_ctrl_t                   mac_ctrl;
    logic signed [RHS_W-1:0]         mac_rhs;
    logic                            mac_sat;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign is_flow  = accept && (cmd == CMD_FLOW);
    assign kern_we  = accept && (cmd == CMD_KERNEL) && (int'(kernel_index) < MAX_PERIOD);
    assign kaddr    = IDX_W'(kernel_index);
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    assign p = eff_period(period_steps_reg);

    always_comb
    begin
        terms = p;
        if (truncated_mode_reg)
        begin
            terms = (term_count_reg == '0) ? PERIOD_W'(1) : term_count_reg;
            if (terms > p)
            begin
                terms = p;
            end
        end
    end

    assign head_inc   = HW'(head_reg) + HW'(1);
    assign head_next  = (head_inc >= HW'(p)) ? '0 : IDX_W'(head_inc);
    assign head_cur   = is_flow ? head_next : head_reg;
    assign count_next = (is_flow && (count_reg < p)) ? count_reg + PERIOD_W'(1) : count_reg;
    assign full_now   = (count_next >= p);

    // writes happen only at item transfer in S_IDLE; read data is used only when issued in S_RUN: no overlap
    always_ff @(posedge clk)
    begin
        if (is_flow)
        begin
            flow_mem[head_next] <= sat_store(flow_sample);
        end
        if (kern_we)
        begin
            kern_mem[kaddr] <= sat_store(kernel_value);
        end
        flow_rd_reg <= flow_mem[ptr_reg];
        kern_rd_reg <= kern_mem[IDX_W'(m_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (kern_we && (kernel_index == '0))
        begin
            kernel0_reg <= sat_store(kernel_value);
        end
    end

    assign diag_neg = -((DIAG_W + 1)'(kernel0_reg));
    assign diag_now = (diag_neg > DMAX) ? DIAG_W'(DMAX) : DIAG_W'(diag_neg);

    assign mac_ctrl.clear      = accept;
    assign mac_ctrl.mul_en     = rd_vld_reg;
    assign mac_ctrl.acc_prod   = prod_vld_reg;
    assign mac_ctrl.acc_offset = (state_reg == S_OFFSET);
    assign mac_ctrl.round      = (state_reg == S_ROUND);

    pkc_mac #(
        .STORE_W (STORE_W),
        .ACC_W   (ACC_W)
    ) u_mac (
        .clk         (clk),
        .ctrl        (mac_ctrl),
        .kernel_word (kern_rd_reg),
        .flow_word   (flow_rd_reg),
        .offset      (pressure_offset_reg),
        .rhs         (mac_rhs),
        .sat         (mac_sat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            pressure_offset_reg <= '0;
            period_steps_reg    <= PERIOD_W'(PERIOD_RESET);
            truncated_mode_reg  <= 1'b0;
            term_count_reg      <= PERIOD_W'(TERM_RESET);
            head_reg            <= IDX_W'(eff_period(PERIOD_W'(PERIOD_RESET)) - PERIOD_W'(1));
            count_reg           <= '0;
            ptr_reg             <= '0;
            m_reg               <= '0;
            last_reg            <= '0;
            full_reg            <= 1'b0;
            drain_reg           <= 1'b0;
            rd_vld_reg          <= 1'b0;
            prod_vld_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            rd_vld_reg   <= (state_reg == S_RUN);
            prod_vld_reg <= rd_vld_reg;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        head_reg  <= head_cur;
                        count_reg <= count_next;
                        full_reg  <= full_now;
                        ptr_reg   <= head_cur;
                        m_reg     <= PERIOD_W'(1);
                        last_reg  <= terms - PERIOD_W'(1);
                        if (full_now && (terms > PERIOD_W'(1)))
                        begin
                            state_reg <= S_RUN;
                        end
                        else
                        begin
                            state_reg <= S_OFFSET;
                        end
                    end
                end
                S_RUN:
                begin
                    m_reg   <= m_reg + PERIOD_W'(1);
                    ptr_reg <= (ptr_reg == '0) ? IDX_W'(p - PERIOD_W'(1)) : ptr_reg - IDX_W'(1);
                    if (m_reg == last_reg)
                    begin
                        state_reg <= S_DRAIN;
                        drain_reg <= 1'b0;
                    end
                end
                S_DRAIN:
                begin
                    // read register and product register still in flight
                    drain_reg <= 1'b1;
                    if (drain_reg)
                    begin
                        state_reg <= S_OFFSET;
                    end
                end
                S_OFFSET:
                begin
                    state_reg <= S_ROUND;
                end
                S_ROUND:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (cfg_write)
            begin
                case (cfg_index)
                    REG_PRESSURE_OFFSET:
                    begin
                        pressure_offset_reg <= cfg_data;
                    end
                    REG_PERIOD_STEPS:
                    begin
                        period_steps_reg <= cfg_data[PERIOD_W-1:0];
                        head_reg  <= IDX_W'(eff_period(cfg_data[PERIOD_W-1:0]) - PERIOD_W'(1));
                        count_reg <= '0;
                    end
                    REG_TRUNCATED_MODE:
                    begin
                        truncated_mode_reg <= cfg_data[0];
                    end
                    REG_TERM_COUNT:
                    begin
                        term_count_reg <= cfg_data[PERIOD_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            rhs_reg      <= mac_rhs;
            sat_reg      <= mac_sat;
            full_out_reg <= full_reg;
            diag_reg     <= diag_now;
        end
    end

    assign out_valid    = out_valid_reg;
    assign rhs_term     = rhs_reg;
    assign diag_coeff   = diag_reg;
    assign history_full = full_out_reg;
    assign saturated    = sat_reg;

    // last product must land before the offset add and the rounding step
    a_drain_done: assert property (@(posedge clk) disable iff (!rst_n)
        prod_vld_reg |-> (state_reg != S_OFFSET) && (state_reg != S_ROUND))
        else $error("product accumulated after offset stage began");

    a_head_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        HW'(head_reg) < HW'(p))
        else $error("ring head outside period");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= p)
        else $error("accepted count beyond period");

    a_run_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (m_reg <= last_reg) && (HW'(ptr_reg) < HW'(p)))
        else $error("lag counter or read pointer out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) && out_valid_reg && out_stall |=> (state_reg == S_OUT))
        else $error("result loaded over a pending transfer");

endmodule
